>>> sv/nearest_car_elevator_dispatch_unit_macros.svh
// Assertion macros shared by the dispatcher RTL.
`ifndef NEAREST_CAR_ELEVATOR_DISPATCH_UNIT_MACROS_SVH
`define NEAREST_CAR_ELEVATOR_DISPATCH_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ncd_pkg.sv
package ncd_pkg;

  localparam int CARS        = 4;
  localparam int FLOORS      = 64;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_ACTIVE  = 4;
  localparam int ACT_LIM     = (CARS < MAX_ACTIVE) ? CARS : MAX_ACTIVE;

  localparam int FLOOR_W = 6;
  localparam int CAR_W   = 2;
  localparam int CFG_W   = 3;
  localparam int ACT_W   = 2;
  localparam int HEAD_W  = 2;
  localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ACT_W-1:0] ACT_HALL = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CAR  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  localparam logic [HEAD_W-1:0] HEAD_UP   = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_DOWN = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_IDLE = 2'd2;

  localparam logic [CFG_W-1:0] CARS_IN_USE_RST = 3'd2;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Request token that walks down the row of car cells.
  typedef struct packed {
    logic               vld;
    logic [ACT_W-1:0]   op;
    logic [FLOOR_W-1:0] floor;
    logic [CAR_W-1:0]   car;        // best car so far, or the named car
    logic [FLOOR_W-1:0] best_span;  // best distance so far
    logic               allowed;    // request may be queued at all
  } tok_t;

  // Enqueue command broadcast to all cells.
  typedef struct packed {
    logic               vld;
    logic [CAR_W-1:0]   car;
    logic [FLOOR_W-1:0] floor;
  } enq_t;

  // Tick report from one cell.
  typedef struct packed {
    logic               vld;
    logic [FLOOR_W-1:0] floor;
    logic [HEAD_W-1:0]  heading;
    logic               accepted;
    logic               last;
  } rep_t;

endpackage

>>> sv/nearest_car_elevator_dispatch_unit.sv
// Nearest-car elevator dispatcher, one request at a time.
// A request is registered and its token walks the registers of the car cells; a tick
// report for active car i leaves as the token reaches cell i, and a call is enqueued
// and acknowledged in the commit state after the walk. busy stays high until the walk,
// or for a call the commit, is done, so no new request is taken sooner; the walk sets the rate.
// Results cannot be stalled. Reset (rst_n low, synchronous) parks all cars at floor 0
// with empty queues and sets cars_in_use to 2.
`include "nearest_car_elevator_dispatch_unit_macros.svh"

module nearest_car_elevator_dispatch_unit import ncd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [FLOOR_W-1:0] in_floor,
  input  logic [CAR_W-1:0]   in_car,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  output logic               out_valid,
  output logic               out_kind,
  output logic [CAR_W-1:0]   out_car_index,
  output logic [FLOOR_W-1:0] out_car_floor,
  output logic [HEAD_W-1:0]  out_heading,
  output logic               out_accepted,
  output logic               out_last
);

  // Controller states: idle, token walking the cells, enqueue and acknowledge.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   cars_r;
  logic [CFG_W-1:0]   n_act;
  logic               accept;
  logic [FLOOR_W-1:0] floor_sat;
  tok_t               tok_in_r, tok_in_nxt;
  tok_t               commit_r;
  tok_t               tok [CARS+1];
  rep_t               rep [CARS];
  logic [CARS-1:0]    rep_vld;
  logic [CARS-1:0]    room;
  logic [CARS-1:0]    active;
  logic [CARS-1:0]    is_last;
  enq_t               enq;
  rep_t               rep_sel;
  logic [CAR_W-1:0]   rep_idx;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [CAR_W-1:0]   out_car_index_r, out_car_index_nxt;
  logic [FLOOR_W-1:0] out_car_floor_r, out_car_floor_nxt;
  logic [HEAD_W-1:0]  out_heading_r, out_heading_nxt;
  logic               out_accepted_r, out_accepted_nxt;
  logic               out_last_r, out_last_nxt;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Clamp the active car count to 1 .. ACT_LIM.
  always_comb begin
    if (cars_r == '0) begin
      n_act = CFG_W'(1);
    end else if (cars_r > CFG_W'(ACT_LIM)) begin
      n_act = CFG_W'(ACT_LIM);
    end else begin
      n_act = cars_r;
    end
  end

  always_comb begin
    for (int i = 0; i < CARS; i++) begin
      active[i]  = (CFG_W'(i) < n_act);
      is_last[i] = (CFG_W'(i + 1) == n_act);
    end
  end

  // Saturate floors beyond the building.
  assign floor_sat = (int'(in_floor) >= FLOORS) ? FLOOR_W'(FLOORS - 1) : in_floor;

  // Load a fresh token into the head of the row; an unknown action yields nothing.
  always_comb begin
    tok_in_nxt         = tok_in_r;
    tok_in_nxt.vld     = accept && (in_action != ACT_NONE);
    if (accept) begin
      tok_in_nxt.op        = in_action;
      tok_in_nxt.floor     = floor_sat;
      tok_in_nxt.car       = in_car;
      tok_in_nxt.best_span = '0;
      tok_in_nxt.allowed   = (in_action == ACT_HALL) || ({1'b0, in_car} < n_act);
    end
  end

  assign tok[0] = tok_in_r;

  for (genvar g = 0; g < CARS; g++) begin : g_cell
    ncd_car_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (CAR_W'(g)),
      .active   (active[g]),
      .is_last  (is_last[g]),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .enq      (enq),
      .room     (room[g]),
      .rep      (rep[g])
    );
    assign rep_vld[g] = rep[g].vld;
  end

  // Only the cell holding the token can report, so a plain select suffices.
  always_comb begin
    rep_sel = '0;
    rep_idx = '0;
    for (int i = 0; i < CARS; i++) begin
      if (rep[i].vld) begin
        rep_sel = rep[i];
        rep_idx = CAR_W'(i);
      end
    end
  end

  // Broadcast the enqueue to the chosen car while acknowledging.
  always_comb begin
    enq.vld   = (state_r == S_COMMIT) && commit_r.allowed;
    enq.car   = commit_r.car;
    enq.floor = commit_r.floor;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_action != ACT_NONE)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok[CARS].vld) begin
          state_nxt = (tok[CARS].op == ACT_TICK) ? S_IDLE : S_COMMIT;
        end
      end
      S_COMMIT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Drive the result registers: tick reports during the walk, the ack on commit.
  always_comb begin
    out_valid_nxt     = 1'b0;
    out_kind_nxt      = out_kind_r;
    out_car_index_nxt = out_car_index_r;
    out_car_floor_nxt = out_car_floor_r;
    out_heading_nxt   = out_heading_r;
    out_accepted_nxt  = out_accepted_r;
    out_last_nxt      = out_last_r;
    priority if (state_r == S_COMMIT) begin
      out_valid_nxt     = 1'b1;
      out_kind_nxt      = KIND_ACK;
      out_car_index_nxt = commit_r.car;
      out_car_floor_nxt = commit_r.floor;
      out_heading_nxt   = HEAD_IDLE;
      out_accepted_nxt  = commit_r.allowed && room[commit_r.car];
      out_last_nxt      = 1'b1;
    end else if (rep_sel.vld) begin
      out_valid_nxt     = 1'b1;
      out_kind_nxt      = KIND_REPORT;
      out_car_index_nxt = rep_idx;
      out_car_floor_nxt = rep_sel.floor;
      out_heading_nxt   = rep_sel.heading;
      out_accepted_nxt  = rep_sel.accepted;
      out_last_nxt      = rep_sel.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cars_r       <= CARS_IN_USE_RST;
      tok_in_r.vld <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tok_in_r    <= tok_in_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cars_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: hold the finished token and the result fields.
  always_ff @(posedge clk) begin
    if ((state_r == S_SCAN) && tok[CARS].vld) begin
      commit_r <= tok[CARS];
    end
    out_kind_r      <= out_kind_nxt;
    out_car_index_r <= out_car_index_nxt;
    out_car_floor_r <= out_car_floor_nxt;
    out_heading_r   <= out_heading_nxt;
    out_accepted_r  <= out_accepted_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_car_index = out_car_index_r;
  assign out_car_floor = out_car_floor_r;
  assign out_heading   = out_heading_r;
  assign out_accepted  = out_accepted_r;
  assign out_last      = out_last_r;

  `NCD_ASSERT_NOW(a_one_reporter, 1'b1, $onehot0(rep_vld), "two cells report at once")
  `NCD_ASSERT_NEXT(a_start_busy, accept && (in_action != ACT_NONE), busy, "request not held")
  `NCD_ASSERT_NOW(a_tok_in_scan, tok[CARS].vld, state_r == S_SCAN, "token out of scan")
  `NCD_ASSERT_NEXT(a_commit_ack, state_r == S_COMMIT, out_valid_r && (out_kind_r == KIND_ACK), "ack missing after commit")

endmodule

>>> sv/ncd_car_cell.sv
module ncd_car_cell import ncd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CAR_W-1:0] cell_idx,
  input  logic             active,
  input  logic             is_last,
  input  tok_t             tok_i,
  output tok_t             tok_o,
  input  enq_t             enq,
  output logic             room,
  output rep_t             rep
);

  logic [FLOOR_W-1:0] pos_r, pos_nxt;
  logic [QIDX_W-1:0]  head_r, head_nxt;
  logic [QIDX_W-1:0]  tail_r, tail_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic [FLOOR_W-1:0] mem [QUEUE_DEPTH];
  logic [FLOOR_W-1:0] rdata_r;
  tok_t               tok_r, tok_nxt;
  logic               wr_en;
  logic               tick_here;
  logic               pop;
  logic [FLOOR_W-1:0] span;

  assign room      = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign wr_en     = enq.vld && (enq.car == cell_idx) && room;
  assign tick_here = tok_i.vld && (tok_i.op == ACT_TICK) && active;
  assign pop       = tick_here && (count_r != '0);
  assign span      = (pos_r > tok_i.floor) ? (pos_r - tok_i.floor) : (tok_i.floor - pos_r);

  // Update the running nearest-car choice and hand the token on.
  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.vld && (tok_i.op == ACT_HALL) && active) begin
      if ((cell_idx == '0) || (span < tok_i.best_span)) begin
        tok_nxt.best_span = span;
        tok_nxt.car       = cell_idx;
      end
    end
  end

  always_comb begin
    rep.vld      = tick_here;
    rep.last     = is_last;
    rep.accepted = pop;
    rep.floor    = pop ? rdata_r : pos_r;
    if (!pop) begin
      rep.heading = HEAD_IDLE;
    end else if (rdata_r > pos_r) begin
      rep.heading = HEAD_UP;
    end else begin
      rep.heading = HEAD_DOWN;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (pop) begin
      pos_nxt   = rdata_r;
      head_nxt  = (head_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else if (wr_en) begin
      tail_nxt  = (tail_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      tok_r.vld <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // Target FIFO storage; front entry is read every cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= enq.floor;
    end
    rdata_r <= mem[head_r];
  end

  assign tok_o = tok_r;

endmodule
